>>> rtl/wda_pkg.sv
// wda_pkg: shared types, constants and command/status structs for the window density accumulator
// no dependencies
package wda_pkg;

  localparam int unsigned DefMaxCols = 16;
  localparam int unsigned DefMaxRows = 16;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERR     = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [2:0] REG_BOX_LEFT   = 3'd0;
  localparam logic [2:0] REG_BOX_BOTTOM = 3'd1;
  localparam logic [2:0] REG_BOX_RIGHT  = 3'd2;
  localparam logic [2:0] REG_BOX_TOP    = 3'd3;
  localparam logic [2:0] REG_WIN_SIZE   = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] rect_left;
    logic [15:0] rect_bottom;
    logic [15:0] rect_right;
    logic [15:0] rect_top;
    logic        shade;
    logic [3:0]  window_col;
    logic [3:0]  window_row;
  } in_word_t;

  typedef struct packed {
    logic [31:0] total_a;
    logic [31:0] total_b;
    logic [31:0] abs_difference;
    logic [8:0]  windows_hit;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [15:0] box_left;
    logic [15:0] box_bottom;
    logic [15:0] box_right;
    logic [15:0] box_top;
    logic [12:0] window_size;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture item, start grid sizing
    logic div_step;   // one quotient bit for both divisions
    logic check;      // latch grid verdict
    logic row_first;  // set row 0
    logic row_next;
    logic col_first;  // set col 0, row overlap ready
    logic col_next;
    logic rd_mem;     // read current window
    logic wr_mem;     // write accumulated window
    logic clr_step;   // clear one entry
    logic emit;       // present result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic grid_bad;
    logic grid_empty; // no columns or no rows
    logic rect_bad;
    logic row_last;
    logic col_last;
    logic row_hit;
    logic col_hit;
    logic clr_last;
  } stat_t;

endpackage

>>> rtl/window_density_accumulator.sv
// window_density_accumulator: top level with the configuration registers
// depends on wda_pkg, wda_ctrl, wda_datapath
//
// One word per start while busy is low; its result shows on out_ for one cycle,
// marked by out_valid, and cannot be held off. A read is paced by the 17-step
// ceiling division that sizes the grid. An add runs the same division, then walks
// the rows and columns it visits, with a read and then a saturating write-back
// of the shade's store for each window hit. A clear sweeps both stores, one entry
// a cycle over all MAX_COLS*MAX_ROWS entries; after reset the same sweep runs
// before busy falls.
module window_density_accumulator #(
  parameter int unsigned MAX_COLS = wda_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = wda_pkg::DefMaxRows
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  wda_pkg::in_word_t  in_word,
  output logic               out_valid,
  output wda_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  wda_pkg::cfg_t  cfg_r;
  wda_pkg::cmd_t  cmd;
  wda_pkg::stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{box_left: 16'd0, box_bottom: 16'd0, box_right: 16'd0, box_top: 16'd0,
                 window_size: 13'd1};
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        wda_pkg::REG_BOX_LEFT:   cfg_r.box_left <= pwdata[15:0];
        wda_pkg::REG_BOX_BOTTOM: cfg_r.box_bottom <= pwdata[15:0];
        wda_pkg::REG_BOX_RIGHT:  cfg_r.box_right <= pwdata[15:0];
        wda_pkg::REG_BOX_TOP:    cfg_r.box_top <= pwdata[15:0];
        wda_pkg::REG_WIN_SIZE:   cfg_r.window_size <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      wda_pkg::REG_BOX_LEFT:   prdata[15:0] = cfg_r.box_left;
      wda_pkg::REG_BOX_BOTTOM: prdata[15:0] = cfg_r.box_bottom;
      wda_pkg::REG_BOX_RIGHT:  prdata[15:0] = cfg_r.box_right;
      wda_pkg::REG_BOX_TOP:    prdata[15:0] = cfg_r.box_top;
      wda_pkg::REG_WIN_SIZE:   prdata[12:0] = cfg_r.window_size;
      default: ;
    endcase
  end
  assign pready = 1'b1;

  wda_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .kind(in_word.kind),
    .stat(stat), .cmd(cmd), .busy(busy), .strobe(out_valid)
  );

  wda_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .item(in_word),
    .cmd(cmd), .stat(stat), .result(out_word)
  );

  // a result only follows a cycle of emitting
  a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.emit)) else $error("result without emit");

  // store never written while clearing
  a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_step && cmd.wr_mem)) else $error("write during clear");

  // no new word taken while a result is due
  a_busy_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> busy) else $error("emit while idle");

endmodule

>>> rtl/wda_datapath.sv
// wda_datapath: grid sizing dividers, window walk, overlap multiply and the two total stores
// depends on wda_pkg
module wda_datapath #(
  parameter int unsigned MAX_COLS = wda_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = wda_pkg::DefMaxRows
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wda_pkg::cfg_t      cfg,
  input  wda_pkg::in_word_t  item,
  input  wda_pkg::cmd_t      cmd,
  output wda_pkg::stat_t     stat,
  output wda_pkg::out_word_t result
);

  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QW    = 17;

  wda_pkg::in_word_t item_r;
  logic [QW-1:0] wn_r, hn_r, qc_r, qr_r, rc_r, rr_r;
  logic [4:0]    dcnt_r;
  logic          wneg_r, hneg_r, zsz_r;
  logic [QW-1:0] cols_r, rows_r;
  logic [8:0]    row_r, col_r;
  logic [16:0]   oy_r, ox_r;
  logic [31:0]   area_r;
  logic [31:0]   mem_a [DEPTH];
  logic [31:0]   mem_b [DEPTH];
  logic [31:0]   rda_r, rdb_r;
  logic [AW-1:0] clr_r;
  logic [8:0]    hits_r;
  logic          gbad_r;

  // grid extents, plus size-1 for ceiling division
  logic [16:0] w_full, h_full;
  assign w_full = {1'b0, cfg.box_right} - {1'b0, cfg.box_left};
  assign h_full = {1'b0, cfg.box_top} - {1'b0, cfg.box_bottom};

  // restoring division, one quotient bit per cycle for columns and rows
  logic [QW:0] trc, trr;
  assign trc = {rc_r, wn_r[QW-1]} - {5'd0, cfg.window_size};
  assign trr = {rr_r, hn_r[QW-1]} - {5'd0, cfg.window_size};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
      wneg_r <= w_full[16];
      hneg_r <= h_full[16];
      zsz_r  <= (cfg.window_size == 13'd0);
      wn_r   <= w_full + {4'd0, cfg.window_size} - 17'd1;
      hn_r   <= h_full + {4'd0, cfg.window_size} - 17'd1;
      rc_r   <= '0;
      rr_r   <= '0;
      qc_r   <= '0;
      qr_r   <= '0;
    end else if (cmd.div_step) begin
      wn_r <= {wn_r[QW-2:0], 1'b0};
      hn_r <= {hn_r[QW-2:0], 1'b0};
      if (!trc[QW]) begin
        rc_r <= trc[QW-1:0];
        qc_r <= {qc_r[QW-2:0], 1'b1};
      end else begin
        rc_r <= {rc_r[QW-2:0], wn_r[QW-1]};
        qc_r <= {qc_r[QW-2:0], 1'b0};
      end
      if (!trr[QW]) begin
        rr_r <= trr[QW-1:0];
        qr_r <= {qr_r[QW-2:0], 1'b1};
      end else begin
        rr_r <= {rr_r[QW-2:0], hn_r[QW-1]};
        qr_r <= {qr_r[QW-2:0], 1'b0};
      end
    end
  end

  // division step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.load) begin
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 5'd1;
    end
  end
  assign stat.div_done = (dcnt_r == 5'(QW - 1));

  // grid verdict
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      cols_r <= qc_r;
      rows_r <= qr_r;
      gbad_r <= zsz_r || wneg_r || hneg_r ||
                (qc_r > QW'(MAX_COLS)) || (qr_r > QW'(MAX_ROWS));
    end
  end
  assign stat.grid_bad = gbad_r;
  assign stat.grid_empty = (cols_r == '0) || (rows_r == '0);
  assign stat.rect_bad = (item_r.rect_right <= item_r.rect_left) ||
                         (item_r.rect_top <= item_r.rect_bottom);

  // window starts along the walk
  logic [17:0] wy, wx, wy_end, wx_end;
  logic [17:0] ylo, yhi, xlo, xhi;
  logic [17:0] ybs, xbs;
  assign ybs = (row_r == 9'(rows_r - 17'd1)) ?
               ({2'b0, cfg.box_top} - {5'd0, cfg.window_size}) : 18'(oy_r);
  assign xbs = (col_r == 9'(cols_r - 17'd1)) ?
               ({2'b0, cfg.box_right} - {5'd0, cfg.window_size}) : 18'(ox_r);
  assign wy = ybs;
  assign wx = xbs;
  assign wy_end = wy + {5'd0, cfg.window_size};
  assign wx_end = wx + {5'd0, cfg.window_size};

  // running origins kept in oy_r/ox_r before the overlap is taken
  logic [16:0] ystart_r, xstart_r;
  logic [17:0] yov, xov;
  always_comb begin
    ylo = ($signed(wy) > $signed({2'b0, item_r.rect_bottom})) ? wy :
          {2'b0, item_r.rect_bottom};
    yhi = ($signed(wy_end) < $signed({2'b0, item_r.rect_top})) ? wy_end :
          {2'b0, item_r.rect_top};
    xlo = ($signed(wx) > $signed({2'b0, item_r.rect_left})) ? wx :
          {2'b0, item_r.rect_left};
    xhi = ($signed(wx_end) < $signed({2'b0, item_r.rect_right})) ? wx_end :
          {2'b0, item_r.rect_right};
    yov = ($signed(yhi) > $signed(ylo)) ? (yhi - ylo) : 18'd0;
    xov = ($signed(xhi) > $signed(xlo)) ? (xhi - xlo) : 18'd0;
  end

  logic [13:0] oyv_r;
  always_ff @(posedge clk) begin
    if (cmd.row_first) begin
      row_r <= '0;
      ystart_r <= {1'b0, cfg.box_bottom};
    end else if (cmd.row_next) begin
      row_r <= row_r + 9'd1;
      ystart_r <= ystart_r + {4'd0, cfg.window_size};
    end
    if (cmd.col_first) begin
      col_r <= '0;
      xstart_r <= {1'b0, cfg.box_left};
      oyv_r <= yov[13:0];
    end else if (cmd.col_next) begin
      col_r <= col_r + 9'd1;
      xstart_r <= xstart_r + {4'd0, cfg.window_size};
    end
    if (cmd.rd_mem) area_r <= 32'(oyv_r) * 32'(xov[13:0]);
  end
  always_comb begin
    oy_r = ystart_r;
    ox_r = xstart_r;
  end

  assign stat.row_last = (17'(row_r) + 17'd1 >= rows_r);
  assign stat.col_last = (17'(col_r) + 17'd1 >= cols_r);
  assign stat.row_hit  = (yov != 18'd0);
  assign stat.col_hit  = (xov != 18'd0);

  // store address: walk position, read address, or clear sweep
  logic [AW-1:0] walk_addr, read_addr;
  assign walk_addr = AW'(row_r[RW-1:0]) * AW'(MAX_COLS) + AW'(col_r[CW-1:0]);
  assign read_addr = AW'(item_r.window_row) * AW'(MAX_COLS) + AW'(item_r.window_col);
  logic [AW-1:0] walk_addr_r;

  // totals memories, registered read, saturating write-back
  logic [32:0] sum;
  assign sum = {1'b0, (item_r.shade ? rdb_r : rda_r)} + {1'b0, area_r};
  always_ff @(posedge clk) begin
    if (cmd.rd_mem) begin
      walk_addr_r <= walk_addr;
      rda_r <= mem_a[walk_addr];
      rdb_r <= mem_b[walk_addr];
    end else if (cmd.check) begin
      rda_r <= mem_a[read_addr];
      rdb_r <= mem_b[read_addr];
    end
    if (cmd.clr_step) begin
      mem_a[clr_r] <= '0;
      mem_b[clr_r] <= '0;
    end else if (cmd.wr_mem) begin
      if (item_r.shade) mem_b[walk_addr_r] <= sum[32] ? '1 : sum[31:0];
      else              mem_a[walk_addr_r] <= sum[32] ? '1 : sum[31:0];
    end
  end

  // clear sweep counter, back to entry 0 after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= stat.clr_last ? '0 : clr_r + AW'(1);
    end
  end
  assign stat.clr_last = (clr_r == AW'(DEPTH - 1));

  // hit counter
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      hits_r <= '0;
    end else if (cmd.wr_mem) begin
      hits_r <= hits_r + 9'd1;
    end
  end

  // result word
  logic outside;
  wda_pkg::out_word_t result_nxt;
  assign outside = (17'(item_r.window_col) >= cols_r) || (17'(item_r.window_row) >= rows_r);
  always_comb begin
    result_nxt = '0;
    case (item_r.kind)
      wda_pkg::KIND_ADD: begin
        if (stat.rect_bad || gbad_r) result_nxt.status = wda_pkg::ST_ERR;
        else result_nxt.windows_hit = hits_r;
      end
      wda_pkg::KIND_READ: begin
        if (gbad_r) result_nxt.status = wda_pkg::ST_ERR;
        else if (outside) result_nxt.status = wda_pkg::ST_OUTSIDE;
        else begin
          result_nxt.total_a = rda_r;
          result_nxt.total_b = rdb_r;
          result_nxt.abs_difference = (rda_r > rdb_r) ? rda_r - rdb_r : rdb_r - rda_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) result <= result_nxt;
  end

endmodule

>>> rtl/wda_ctrl.sv
// wda_ctrl: sequencer for sizing, window walk, read and clear sweep
// depends on wda_pkg
module wda_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [1:0]     kind,
  input  wda_pkg::stat_t stat,
  output wda_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           strobe
);

  typedef enum logic [10:0] {
    S_INIT  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_DIV   = 11'b00000000100,
    S_CHECK = 11'b00000001000,
    S_ROW   = 11'b00000010000,
    S_COL   = 11'b00000100000,
    S_RD    = 11'b00001000000,
    S_WR    = 11'b00010000000,
    S_CLR   = 11'b00100000000,
    S_EMIT  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] kind_r;
  logic strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      strobe_r <= 1'b0;
      kind_r <= wda_pkg::KIND_ADD;
    end else begin
      state_r <= state_nxt;
      strobe_r <= (state_r == S_EMIT);
      if (start && state_r == S_IDLE) kind_r <= kind;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = (kind == wda_pkg::KIND_CLEAR) ? S_CLR :
                      (kind == wda_pkg::KIND_SPARE) ? S_EMIT : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cmd.row_first = 1'b1;
        if (kind_r == wda_pkg::KIND_ADD && !stat.rect_bad) state_nxt = S_ROW;
        else state_nxt = S_EMIT;
      end
      S_ROW: begin
        if (stat.grid_bad || stat.rect_bad || stat.grid_empty) state_nxt = S_EMIT;
        else if (stat.row_last && !stat.row_hit) state_nxt = S_EMIT;
        else if (!stat.row_hit) cmd.row_next = 1'b1;
        else begin
          cmd.col_first = 1'b1;
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        if (stat.col_hit) begin
          cmd.rd_mem = 1'b1;
          state_nxt = S_WR;
        end else state_nxt = S_RD;
      end
      S_RD: begin
        if (!stat.col_last) begin
          cmd.col_next = 1'b1;
          state_nxt = S_COL;
        end else if (!stat.row_last) begin
          cmd.row_next = 1'b1;
          state_nxt = S_ROW;
        end else state_nxt = S_EMIT;
      end
      S_WR: begin
        cmd.wr_mem = 1'b1;
        state_nxt = S_RD;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign strobe = strobe_r;

endmodule
